/* hw/rtl/sbpo_pkg.sv */
// package: widths for sphere box push out
`timescale 1ns / 1ps
package sbpo_pkg;
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 12;
endpackage

/* hw/rtl/sbpo_divider.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module sbpo_divider #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 26,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);
    logic [NUM_W:0]   r_vld;
    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [NUM_W-1:0] r_quo [NUM_W+1];
    logic [DEN_W:0]   r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num;
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W+1:0] w_sh;
        logic [DEN_W+1:0] w_df;
        assign w_sh = {r_rem[k], r_num[k][NUM_W-1]};
        assign w_df = w_sh - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= {r_num[k][NUM_W-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
                if (!w_df[DEN_W+1]) begin
                    r_rem[k+1] <= w_df[DEN_W:0];
                    r_quo[k+1] <= {r_quo[k][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= w_sh[DEN_W:0];
                    r_quo[k+1] <= {r_quo[k][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_quo[NUM_W];
    assign o_tag   = r_tag[NUM_W];
endmodule

/* hw/rtl/sphere_box_push_out.sv */
// top level: sphere versus box push out, fully pipelined
//
// usage
//   slave channel s_axis carries one query per transfer: sphere centre, radius,
//   box centre and half extents packed into s_axis_tdata. master channel m_axis
//   returns one result per query in the same order: new centre and hit flag.
//   throughput is one query per clock while results are taken. from the
//   accepting edge to m_axis_tvalid a query passes three front stages, a
//   bit-per-stage square root of CW+2 stages, two numerator stages, a
//   bit-per-stage divider and the output register.
//   the whole pipe advances on one enable: when
//   the output register holds a result that the receiver does not take,
//   every stage holds and s_axis_tready drops; nothing is lost or repeated.
//   reset (i_rst_n low, synchronous) clears all valid bits; payload stages
//   are not reset. zero length gives hit with no movement, zero radius never
//   hits, results saturate to the signed coordinate range.
//   s_axis_tready is high whenever the output slot is empty or being taken.
`timescale 1ns / 1ps
module sphere_box_push_out #(
    parameter int CW = sbpo_pkg::COORD_WIDTH,
    localparam int DW = ((10 * CW - 4) + 7) / 8 * 8,
    localparam int OW = ((3 * CW) + 7) / 8 * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, box_center_x,y,z, box_half_x,y,z
    input  logic [DW-1:0] s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // new_x, new_y, new_z
    output logic [OW-1:0] m_axis_tdata,
    // hit
    output logic          m_axis_tuser
);
    localparam int MW = CW + 1;
    localparam int SQW = 2 * MW + 2;
    localparam int LW = MW + 1;
    localparam int NW = 2 * MW + 2;
    localparam int TW = 3 * CW + 3 * MW + 3 + 1 + 1;
    localparam int SQS = SQW / 2;

    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: clamp
    logic signed [CW-1:0] w_s [3];
    logic signed [CW-1:0] w_c [3];
    logic [CW-2:0] w_h [3];
    logic [CW-2:0] w_r;
    for (genvar a = 0; a < 3; a++) begin : g_unp
        assign w_s[a] = s_axis_tdata[a*CW +: CW];
        assign w_c[a] = s_axis_tdata[3*CW+CW-1+a*CW +: CW];
        assign w_h[a] = s_axis_tdata[6*CW+CW-1+a*(CW-1) +: CW-1];
    end
    assign w_r = s_axis_tdata[3*CW +: CW-1];

    logic                 r1_v;
    logic signed [CW-1:0] r1_s [3];
    logic [MW-1:0]        r1_m [3];
    logic                 r1_neg [3];
    logic [CW-2:0]        r1_r;
    for (genvar a = 0; a < 3; a++) begin : g_cl
        logic signed [CW+1:0] w_lo, w_hi, w_sx, w_d;
        assign w_sx = (CW+2)'(w_s[a]);
        assign w_lo = (CW+2)'(w_c[a]) - $signed({3'b000, w_h[a]});
        assign w_hi = (CW+2)'(w_c[a]) + $signed({3'b000, w_h[a]});
        assign w_d = (w_sx > w_hi) ? w_sx - w_hi : (w_sx < w_lo) ? w_sx - w_lo : '0;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r1_s[a]   <= w_s[a];
                r1_neg[a] <= w_d[CW+1];
                r1_m[a]   <= w_d[CW+1] ? MW'(-w_d) : MW'(w_d);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r1_r <= w_r;
    end

    // stage 2: squares
    logic r2_v;
    logic signed [CW-1:0] r2_s [3];
    logic [MW-1:0] r2_m [3];
    logic r2_neg [3];
    logic [CW-2:0] r2_r;
    logic [2*MW-1:0] r2_q [3];
    logic [2*CW-3:0] r2_rr;
    logic r2_near;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r2_s[a] <= r1_s[a];
                r2_m[a] <= r1_m[a];
                r2_neg[a] <= r1_neg[a];
                r2_q[a] <= r1_m[a] * r1_m[a];
            end
            r2_r  <= r1_r;
            r2_rr <= r1_r * r1_r;
            r2_near <= (r1_m[0] < MW'(r1_r)) && (r1_m[1] < MW'(r1_r))
                    && (r1_m[2] < MW'(r1_r));
        end
    end

    // stage 3: sum and hit
    logic r3_v;
    logic signed [CW-1:0] r3_s [3];
    logic [MW-1:0] r3_m [3];
    logic r3_neg [3];
    logic [CW-2:0] r3_r;
    logic [SQW-1:0] r3_sq;
    logic r3_hit;
    logic [SQW-1:0] w_sum;
    assign w_sum = SQW'(r2_q[0]) + SQW'(r2_q[1]) + SQW'(r2_q[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_s <= r2_s; r3_m <= r2_m; r3_neg <= r2_neg; r3_r <= r2_r;
            r3_sq  <= w_sum;
            r3_hit <= r2_near && (w_sum < SQW'(r2_rr));
        end
    end

    // square root, one result bit per stage
    logic [SQS:0] rq_v;
    logic [SQW-1:0] rq_x [SQS+1];
    logic [SQW-1:0] rq_res [SQS+1];
    logic [TW-1:0] rq_t [SQS+1];
    logic [TW-1:0] w_t3;
    always_comb begin
        w_t3 = '0;
        for (int a = 0; a < 3; a++) begin
            w_t3[a*CW +: CW] = r3_s[a];
            w_t3[3*CW+a*MW +: MW] = r3_m[a];
            w_t3[3*CW+3*MW+a] = r3_neg[a];
        end
        w_t3[TW-2] = r3_hit;
        w_t3[TW-1] = (r3_sq == '0);
    end
    logic [CW-2:0] rq_r [SQS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rq_v <= '0;
        else if (w_en) rq_v <= {rq_v[SQS-1:0], r3_v};
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq_x[0] <= r3_sq; rq_res[0] <= '0; rq_t[0] <= w_t3;
            rq_r[0] <= r3_r;
        end
    end
    for (genvar k = 0; k < SQS; k++) begin : g_sq
        logic [SQW-1:0] w_b, w_tr;
        assign w_b  = SQW'(1) << (2 * (SQS - 1 - k));
        assign w_tr = rq_res[k] + w_b;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                rq_t[k+1] <= rq_t[k]; rq_r[k+1] <= rq_r[k];
                if (rq_x[k] >= w_tr) begin
                    rq_x[k+1]   <= rq_x[k] - w_tr;
                    rq_res[k+1] <= (rq_res[k] >> 1) + w_b;
                end else begin
                    rq_x[k+1]   <= rq_x[k];
                    rq_res[k+1] <= rq_res[k] >> 1;
                end
            end
        end
    end

    // numerator per axis and shared denominator
    logic r4_v;
    logic [TW-1:0] r4_t;
    logic [LW-1:0] r4_len;
    logic [CW-1:0] r4_p;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= rq_v[SQS];
    end
    logic [LW-1:0] w_len;
    assign w_len = LW'(rq_res[SQS]);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_t   <= rq_t[SQS];
            r4_len <= w_len;
            r4_p   <= CW'(rq_r[SQS]) - CW'(w_len);
        end
    end
    logic [MW+CW-1:0] w_mp [3];
    for (genvar a = 0; a < 3; a++) begin : g_mp
        assign w_mp[a] = r4_t[3*CW+a*MW +: MW] * r4_p;
    end
    logic r5_v;
    logic [TW-1:0] r5_t;
    logic [LW-1:0] r5_len;
    logic [NW-1:0] r5_n [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_t <= r4_t; r5_len <= r4_len;
            for (int a = 0; a < 3; a++)
                r5_n[a] <= NW'({w_mp[a], 1'b0}) + NW'(r4_len);
        end
    end

    logic w_dv [3];
    logic [NW-1:0] w_q [3];
    logic [TW-1:0] w_tq [3];
    for (genvar a = 0; a < 3; a++) begin : g_div
        sbpo_divider #(.NUM_W(NW), .DEN_W(LW + 1), .TAG_W(TW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r5_v),
            .i_num   (r5_n[a]),
            .i_den   ({r5_len, 1'b0}),
            .i_tag   (r5_t),
            .o_valid (w_dv[a]),
            .o_quot  (w_q[a]),
            .o_tag   (w_tq[a])
        );
    end

    // apply offset, saturate, output register
    logic [OW-1:0] n_data;
    logic n_hit;
    always_comb begin
        logic signed [NW+1:0] v;
        logic signed [NW+1:0] o;
        n_data = '0;
        n_hit = w_tq[0][TW-2];
        for (int a = 0; a < 3; a++) begin
            o = $signed({2'b00, w_q[a]});
            if (w_tq[0][3*CW+3*MW+a]) o = -o;
            v = (NW+2)'($signed(w_tq[0][a*CW +: CW]));
            if (w_tq[0][TW-2] && !w_tq[0][TW-1]) v = v + o;
            if (v > (NW+2)'($signed({1'b0, {(CW-1){1'b1}}})))
                v = (NW+2)'($signed({1'b0, {(CW-1){1'b1}}}));
            else if (v < (NW+2)'($signed({1'b1, {(CW-1){1'b0}}})))
                v = (NW+2)'($signed({1'b1, {(CW-1){1'b0}}}));
            n_data[a*CW +: CW] = v[CW-1:0];
        end
    end
    logic r_ov;
    logic [OW-1:0] r_od;
    logic r_oh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_dv[0];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od <= n_data;
            r_oh <= n_hit;
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_oh;
endmodule

/* hw/rtl/sbpo_checker.sv */
// checker: port level properties of sphere box push out
`timescale 1ns / 1ps
module sbpo_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tuser
);
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept on stall");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("output dropped");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("valid after reset");
endmodule

bind sphere_box_push_out sbpo_checker u_sbpo_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser)
);

/* bench/tb_sphere_box_push_out.sv */
// testbench: sphere versus box push out, checked against a predictor with random stalls
`timescale 1ns / 1ps
module tb_sphere_box_push_out;
    localparam int CW = sbpo_pkg::COORD_WIDTH;
    localparam int DW = ((10 * CW - 4) + 7) / 8 * 8;
    localparam int OW = ((3 * CW) + 7) / 8 * 8;
    localparam int LATENCY = 3 * CW + 13;
    localparam int N_RANDOM = 1450;
    localparam int WATCHDOG = 20000;
    localparam int HOLD_OFF = 400;
    localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-2:0] UMAX = {(CW-1){1'b1}};

    typedef struct packed {
        logic [CW-2:0] hz, hy, hx;
        logic signed [CW-1:0] bz, by, bx;
        logic [CW-2:0] r;
        logic signed [CW-1:0] sz, sy, sx;
    } t_query;

    typedef struct packed {
        logic hit;
        logic signed [CW-1:0] nz, ny, nx;
    } t_push;

    typedef struct {
        t_query q;
        logic   known;
        t_push  want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // sphere_x, sphere_y, sphere_z, sphere_radius, box_center_x,y,z, box_half_x,y,z
    logic [DW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // new_x, new_y, new_z
    logic [OW-1:0] m_axis_tdata;
    // hit
    logic m_axis_tuser;

    sphere_box_push_out dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_push pending_push[$];
    t_query feed[$];
    int errors = 0;
    int idle_cycles = 0;
    bit feeding_done = 0;
    bit hold_req = 0;

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_push push_out(input t_query q);
        t_push o;
        longint s[3], c[3], d[3], v;
        longint unsigned h[3], m[3], r, dsq, len, p, qq;
        s[0] = q.sx; s[1] = q.sy; s[2] = q.sz;
        c[0] = q.bx; c[1] = q.by; c[2] = q.bz;
        h[0] = q.hx; h[1] = q.hy; h[2] = q.hz;
        r = q.r;
        o.hit = 1'b0;
        o.nx = q.sx; o.ny = q.sy; o.nz = q.sz;
        for (int i = 0; i < 3; i++) begin
            v = s[i];
            if (v > c[i] + longint'(h[i])) v = c[i] + longint'(h[i]);
            if (v < c[i] - longint'(h[i])) v = c[i] - longint'(h[i]);
            d[i] = s[i] - v;
            m[i] = d[i] < 0 ? -d[i] : d[i];
        end
        if (m[0] < r && m[1] < r && m[2] < r) begin
            dsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            if (dsq < r * r) begin
                o.hit = 1'b1;
                if (dsq != 0) begin
                    len = root_floor(dsq);
                    p = r - len;
                    for (int i = 0; i < 3; i++) begin
                        qq = (2 * m[i] * p + len) / (2 * len);
                        v = s[i] + (d[i] < 0 ? -longint'(qq) : longint'(qq));
                        if (v > SMAX) v = SMAX;
                        if (v < SMIN) v = SMIN;
                        if (i == 0) o.nx = CW'(v);
                        else if (i == 1) o.ny = CW'(v);
                        else o.nz = CW'(v);
                    end
                end
            end
        end
        return o;
    endfunction

    function automatic t_query mk(input longint sx, sy, sz, r, bx, by, bz, hx, hy, hz);
        t_query q;
        q.sx = CW'(sx); q.sy = CW'(sy); q.sz = CW'(sz); q.r = (CW-1)'(r);
        q.bx = CW'(bx); q.by = CW'(by); q.bz = CW'(bz);
        q.hx = (CW-1)'(hx); q.hy = (CW-1)'(hy); q.hz = (CW-1)'(hz);
        return q;
    endfunction

    function automatic logic [CW-1:0] rnd_coord(input int spread);
        if (spread == 0) return CW'({$urandom, $urandom});
        return CW'($urandom_range(2 * spread) - spread);
    endfunction

    function automatic logic [CW-2:0] rnd_len(input int spread);
        case ($urandom_range(9))
            0: return '0;
            1: return UMAX;
            2: return (CW-1)'({$urandom, $urandom});
            default: return (CW-1)'($urandom_range(spread));
        endcase
    endfunction

    function automatic t_query rnd_query();
        t_query q;
        int spread;
        spread = ($urandom_range(7) == 0) ? 0 : (1 << $urandom_range(6, 20));
        q.bx = rnd_coord(spread); q.by = rnd_coord(spread); q.bz = rnd_coord(spread);
        q.hx = rnd_len(spread / 2 + 1); q.hy = rnd_len(spread / 2 + 1);
        q.hz = rnd_len(spread / 2 + 1);
        q.r = rnd_len(spread + 1);
        if ($urandom_range(3) != 0 && spread != 0) begin
            // put the centre near the box so that hits are common
            q.sx = q.bx + rnd_coord(spread); q.sy = q.by + rnd_coord(spread);
            q.sz = q.bz + rnd_coord(spread);
        end else begin
            q.sx = rnd_coord(0); q.sy = rnd_coord(0); q.sz = rnd_coord(0);
        end
        return q;
    endfunction

    // sender
    initial begin
        t_row rows[$];
        t_row rw;
        int gap;
        rw.known = 1; rw.want = '0;
        rw.q = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rw.want = '0; rows.push_back(rw);
        // centre inside box: hit without movement
        rw.q = mk(100, -50, 7, 4096, 0, 0, 0, 4096, 4096, 4096);
        rw.want = {1'b1, 24'sd7, -24'sd50, 24'sd100}; rows.push_back(rw);
        // centre on the box face
        rw.q = mk(4096, 0, 0, 1, 0, 0, 0, 4096, 0, 0);
        rw.want = {1'b1, 24'sd0, 24'sd0, 24'sd4096}; rows.push_back(rw);
        // zero radius never hits
        rw.q = mk(5, 5, 5, 0, 5, 5, 5, 0, 0, 0);
        rw.want = {1'b0, 24'sd5, 24'sd5, 24'sd5}; rows.push_back(rw);
        // touching exactly at radius is a miss
        rw.q = mk(200, 0, 0, 100, 0, 0, 0, 100, 0, 0);
        rw.want = {1'b0, 24'sd0, 24'sd0, 24'sd200}; rows.push_back(rw);
        // single axis push
        rw.q = mk(150, 0, 0, 100, 0, 0, 0, 100, 0, 0);
        rw.want = {1'b1, 24'sd0, 24'sd0, 24'sd200}; rows.push_back(rw);
        rw.q = mk(-150, 0, 0, 100, 0, 0, 0, 100, 0, 0);
        rw.want = {1'b1, 24'sd0, 24'sd0, -24'sd200}; rows.push_back(rw);
        rw.q = mk(0, 0, SMAX, UMAX, 0, 0, SMAX - 10, 0, 0, 0);
        rw.want = {1'b1, SMAX, 24'sd0, 24'sd0}; rows.push_back(rw);
        rw.q = mk(SMIN, SMIN, SMIN, UMAX, SMIN + 5, SMIN + 5, SMIN + 5, 0, 0, 0);
        rw.want = {1'b1, SMIN, SMIN, SMIN}; rows.push_back(rw);
        rw.q = mk(SMAX, SMAX, SMAX, UMAX, SMIN, SMIN, SMIN, UMAX, UMAX, UMAX);
        rw.want = {1'b0, SMAX, SMAX, SMAX}; rows.push_back(rw);
        rw.q = mk(SMIN, SMAX, SMIN, UMAX, SMAX, SMIN, SMAX, 0, 0, 0);
        rw.want = {1'b0, SMIN, SMAX, SMIN}; rows.push_back(rw);
        rw.known = 0;
        rw.q = mk(130, 130, 130, 100, 0, 0, 0, 100, 100, 100); rows.push_back(rw);
        rw.q = mk(-130, 140, -110, 80, 0, 0, 0, 100, 100, 100); rows.push_back(rw);
        rw.q = mk(SMAX, SMAX, 0, UMAX, SMAX - 1000, SMAX - 1000, 0, 0, 0, UMAX);
        rows.push_back(rw);
        rw.q = mk(3, 4, 0, 6, 0, 0, 0, 0, 0, 0); rows.push_back(rw);
        rw.q = mk(-3, -4, 12, 13, 0, 0, 0, 0, 0, 0); rows.push_back(rw);
        foreach (rows[i]) begin
            feed.push_back(rows[i].q);
            pending_push.push_back(rows[i].known ? rows[i].want : push_out(rows[i].q));
        end
        repeat (N_RANDOM) begin
            t_query q;
            q = rnd_query();
            feed.push_back(q);
            pending_push.push_back(push_out(q));
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (feed.size() != 0) begin
            s_axis_tdata <= DW'(feed.pop_front());
            s_axis_tvalid <= 1'b1;
            do @(posedge i_clk); while (!s_axis_tready);
            if (feed.size() == 0 || $urandom_range(2) != 0) continue;
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
        feeding_done = 1;
    end

    // receiver with one long hold-off early in the run
    initial begin
        int gap;
        @(posedge i_rst_n);
        repeat (30) @(posedge i_clk);
        hold_req = 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge i_clk);
        hold_req = 0;
        forever begin
            if ($urandom_range(3) == 0) begin
                gap = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_push got, want;
            got = {m_axis_tuser, m_axis_tdata[3*CW-1:0]};
            if (pending_push.size() == 0) begin
                $error("unexpected transfer %h", got);
                errors++;
            end else begin
                want = pending_push.pop_front();
                if (got.nx !== want.nx) begin
                    $error("new_x expected %0d got %0d", want.nx, got.nx); errors++;
                end
                if (got.ny !== want.ny) begin
                    $error("new_y expected %0d got %0d", want.ny, got.ny); errors++;
                end
                if (got.nz !== want.nz) begin
                    $error("new_z expected %0d got %0d", want.nz, got.nz); errors++;
                end
                if (got.hit !== want.hit) begin
                    $error("hit expected %0d got %0d", want.hit, got.hit); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_req)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        do @(posedge i_clk);
        while (!(feeding_done && pending_push.size() == 0) && idle_cycles < WATCHDOG);
        if (idle_cycles < WATCHDOG) begin
            repeat (LATENCY + 20) @(posedge i_clk);
            if (errors == 0 && pending_push.size() == 0)
                $display("tb: success");
            else
                $display("tb: failure");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
